@@ sv/stq_pkg.sv @@
package stq_pkg;

   localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
   localparam logic [31:0] DL_MAX      = 32'hffff_fffe;
   localparam int          MAX_RESULTS = 16;

   // opcodes
   localparam logic [2:0] OP_ALLOC   = 3'd0;
   localparam logic [2:0] OP_FREE    = 3'd1;
   localparam logic [2:0] OP_PAYLOAD = 3'd2;
   localparam logic [2:0] OP_ARM     = 3'd3;
   localparam logic [2:0] OP_TICK    = 3'd4;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOFREE  = 3'd1;
   localparam logic [2:0] ST_BAD     = 3'd2;
   localparam logic [2:0] ST_EXPIRED = 3'd3;
   localparam logic [2:0] ST_NONE    = 3'd4;

   // slot modes
   localparam logic [1:0] MODE_FREE  = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_ARMED = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_LINK,
      S_LINK_PREV,
      S_ARM_DONE,
      S_EXP_RD,
      S_EXP_NX,
      S_EXP_DL
   } state_type;

   typedef enum logic [1:0] {
      DEC_PLAIN,
      DEC_ARM,
      DEC_TICK
   } dec_kind_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_LINK,
      RD_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       capture;
      logic       decode;
      logic       walk_step;
      logic       link_self;
      logic       link_prev;
      logic       arm_done;
      logic       exp_take;
      logic       exp_emit;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      dec_kind_type kind;
      logic         out_busy;
      logic         head_vld;
      logic         walk_stop;
      logic         link_vld;
      logic         prev_vld;
      logic         more;
   } sts_type;

endpackage

@@ sv/stq_ram.sv @@
module stq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ sv/stq_ctrl.sv @@
module stq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::sts_type sts,
   output stq_pkg::cmd_type cmd
);
   import stq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (!sts.out_busy) begin
               case (sts.kind)
                  DEC_ARM:  state_in = sts.head_vld ? S_WALK : S_LINK;
                  DEC_TICK: state_in = S_EXP_RD;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_WALK: begin
            if (sts.walk_stop || !sts.link_vld) state_in = S_LINK;
         end
         S_LINK: begin
            state_in = sts.prev_vld ? S_LINK_PREV : S_ARM_DONE;
         end
         S_LINK_PREV: state_in = S_ARM_DONE;
         S_ARM_DONE: begin
            if (!sts.out_busy) state_in = S_IDLE;
         end
         S_EXP_RD: state_in = S_EXP_NX;
         S_EXP_NX: state_in = S_EXP_DL;
         S_EXP_DL: begin
            if (!sts.out_busy) state_in = sts.more ? S_EXP_RD : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.rd_sel = RD_HEAD;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE:      cmd.capture = req_valid;
         S_DECODE:    cmd.decode = !sts.out_busy;
         S_WALK: begin
            cmd.rd_sel = RD_LINK;
            cmd.walk_step = !sts.walk_stop;
         end
         S_LINK:      cmd.link_self = 1'b1;
         S_LINK_PREV: cmd.link_prev = 1'b1;
         S_ARM_DONE:  cmd.arm_done = !sts.out_busy;
         S_EXP_RD:    cmd.rd_sel = RD_HEAD;
         S_EXP_NX: begin
            cmd.rd_sel = RD_LINK;
            cmd.exp_take = 1'b1;
         end
         S_EXP_DL: begin
            cmd.rd_sel = RD_NEXT;
            cmd.exp_emit = !sts.out_busy;
         end
         default: cmd = '0;
      endcase
   end

endmodule

@@ sv/stq_dpath.sv @@
module stq_dpath #(
   parameter int SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [2:0]       req_opcode,
   input  logic [3:0]       req_slot,
   input  logic [31:0]      req_payload,
   input  logic [2:0]       req_destination,
   input  logic [31:0]      req_delay,
   input  stq_pkg::cmd_type cmd,
   output stq_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_slot_out,
   output logic [31:0]      rsp_payload_out,
   output logic [2:0]       rsp_dest_out,
   output logic             rsp_last
);
   import stq_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int LW = IW + 1;

   // captured request
   logic [2:0]  op_ff;
   logic [3:0]  slot_ff;
   logic [31:0] pl_ff;
   logic [2:0]  ds_ff;
   logic [31:0] dl_ff;

   // queue state
   logic [31:0]   count_ff;
   logic [1:0]    mode_ff [SLOTS];
   logic          head_vld_ff;
   logic [IW-1:0] head_ff;
   logic [31:0]   head_dl_ff;

   // walk and expiry scratch
   logic          cur_vld_ff, prev_vld_ff, nxt_vld_ff;
   logic [IW-1:0] cur_ff, prev_ff, nxt_ff, h_ff;
   logic [31:0]   hpl_ff;
   logic [2:0]    hds_ff;
   logic [4:0]    n_ff;

   // output register
   logic        out_vld_ff;
   logic [2:0]  out_st_ff;
   logic [3:0]  out_sl_ff;
   logic [31:0] out_pl_ff;
   logic [2:0]  out_ds_ff;
   logic        out_last_ff;

   // ram ports
   logic [IW-1:0] rd_addr;
   logic [31:0]   rd_dl;
   logic [LW-1:0] rd_lk;
   logic [34:0]   rd_pd;
   logic          dl_we, lk_we, pd_we;
   logic [IW-1:0] lk_waddr;
   logic [LW-1:0] lk_wdata;

   logic [IW-1:0] slot_idx;
   logic          slot_ok;
   logic [1:0]    slot_mode;
   logic          free_found;
   logic [IW-1:0] free_idx;
   logic [31:0]   count_inc;
   logic [32:0]   sum33;
   logic [31:0]   new_dl;
   dec_kind_type  kind;
   logic [2:0]    dec_st;
   logic [3:0]    dec_sl;
   logic          mode_we;
   logic [IW-1:0] mode_widx;
   logic [1:0]    mode_wval;
   logic [4:0]    n_inc;

   assign slot_idx  = IW'(slot_ff);
   assign slot_ok   = {3'b000, slot_ff} < 7'(SLOTS);
   assign slot_mode = mode_ff[slot_idx];
   assign count_inc = count_ff + 32'd1;
   assign sum33     = {1'b0, count_ff} + {1'b0, dl_ff};
   assign new_dl    = (sum33[32] || sum33[31:0] == ALL_ONES) ? DL_MAX : sum33[31:0];
   assign n_inc     = n_ff + 5'd1;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (mode_ff[i] == MODE_FREE) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   // opcode decode
   always_comb begin
      kind      = DEC_PLAIN;
      dec_st    = ST_BAD;
      dec_sl    = 4'd0;
      mode_we   = 1'b0;
      mode_widx = slot_idx;
      mode_wval = MODE_FREE;
      pd_we     = 1'b0;
      dl_we     = 1'b0;
      case (op_ff)
         OP_ALLOC: begin
            if (free_found) begin
               dec_st    = ST_OK;
               dec_sl    = 4'(free_idx);
               mode_we   = cmd.decode;
               mode_widx = free_idx;
               mode_wval = MODE_ALLOC;
            end else begin
               dec_st = ST_NOFREE;
            end
         end
         OP_FREE: begin
            if (slot_ok && slot_mode == MODE_ALLOC) begin
               dec_st    = ST_OK;
               mode_we   = cmd.decode;
               mode_wval = MODE_FREE;
            end
         end
         OP_PAYLOAD: begin
            if (slot_ok && slot_mode != MODE_FREE) begin
               dec_st = ST_OK;
               pd_we  = cmd.decode;
            end
         end
         OP_ARM: begin
            if (slot_ok && slot_mode == MODE_ALLOC) begin
               kind      = DEC_ARM;
               dec_st    = ST_OK;
               mode_we   = cmd.decode;
               mode_wval = MODE_ARMED;
               dl_we     = cmd.decode;
            end
         end
         OP_TICK: begin
            if (head_vld_ff && head_dl_ff <= count_inc) begin
               kind = DEC_TICK;
            end else begin
               dec_st = ST_NONE;
            end
         end
         default: dec_st = ST_BAD;
      endcase
   end

   // shared read address of the rams
   always_comb begin
      case (cmd.rd_sel)
         RD_LINK: rd_addr = rd_lk[IW-1:0];
         RD_NEXT: rd_addr = nxt_ff;
         default: rd_addr = head_ff;
      endcase
   end

   // link ram writes
   always_comb begin
      lk_we    = cmd.link_self || cmd.link_prev;
      lk_waddr = cmd.link_prev ? prev_ff : slot_idx;
      lk_wdata = cmd.link_prev ? {1'b1, slot_idx} : {cur_vld_ff, cur_ff};
   end

   stq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_dl_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (slot_idx),
      .wr_data (new_dl),
      .rd_addr (rd_addr),
      .rd_data (rd_dl)
   );

   stq_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_lk_ram (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (lk_waddr),
      .wr_data (lk_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_lk)
   );

   stq_ram #(.WIDTH(35), .DEPTH(SLOTS)) u_pd_ram (
      .clock   (clock),
      .wr_en   (pd_we),
      .wr_addr (slot_idx),
      .wr_data ({ds_ff, pl_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_pd)
   );

   // request capture and scratch registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         slot_ff <= req_slot;
         pl_ff   <= req_payload;
         ds_ff   <= req_destination;
         dl_ff   <= req_delay;
      end
      if (cmd.decode && kind == DEC_ARM) begin
         dl_ff       <= new_dl;
         cur_ff      <= head_ff;
         cur_vld_ff  <= head_vld_ff;
         prev_vld_ff <= 1'b0;
      end
      if (cmd.walk_step) begin
         prev_ff     <= cur_ff;
         prev_vld_ff <= 1'b1;
         cur_ff      <= rd_lk[IW-1:0];
         cur_vld_ff  <= rd_lk[IW];
      end
      if (cmd.exp_take) begin
         h_ff       <= head_ff;
         hpl_ff     <= rd_pd[31:0];
         hds_ff     <= rd_pd[34:32];
         nxt_ff     <= rd_lk[IW-1:0];
         nxt_vld_ff <= rd_lk[IW];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         head_vld_ff <= 1'b0;
         head_ff     <= '0;
         head_dl_ff  <= ALL_ONES;
         n_ff        <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            mode_ff[i] <= MODE_FREE;
         end
      end else begin
         if (cmd.decode && op_ff == OP_TICK) begin
            count_ff <= count_inc;
            n_ff     <= '0;
         end
         if (mode_we) begin
            mode_ff[mode_widx] <= mode_wval;
         end
         if (cmd.exp_take) begin
            mode_ff[head_ff] <= MODE_ALLOC;
         end
         if (cmd.link_self && !prev_vld_ff) begin
            head_vld_ff <= 1'b1;
            head_ff     <= slot_idx;
            head_dl_ff  <= dl_ff;
         end
         if (cmd.exp_emit) begin
            head_vld_ff <= nxt_vld_ff;
            head_ff     <= nxt_ff;
            head_dl_ff  <= nxt_vld_ff ? rd_dl : ALL_ONES;
            n_ff        <= n_inc;
         end
      end
   end

   assign sts.more = (32'(n_inc) < 32'(MAX_RESULTS)) && nxt_vld_ff && rd_dl <= count_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.decode && kind == DEC_PLAIN || cmd.arm_done || cmd.exp_emit) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode && kind == DEC_PLAIN) begin
         out_st_ff   <= dec_st;
         out_sl_ff   <= dec_sl;
         out_pl_ff   <= '0;
         out_ds_ff   <= '0;
         out_last_ff <= 1'b1;
      end else if (cmd.arm_done) begin
         out_st_ff   <= ST_OK;
         out_sl_ff   <= '0;
         out_pl_ff   <= '0;
         out_ds_ff   <= '0;
         out_last_ff <= 1'b1;
      end else if (cmd.exp_emit) begin
         out_st_ff   <= ST_EXPIRED;
         out_sl_ff   <= 4'(h_ff);
         out_pl_ff   <= hpl_ff;
         out_ds_ff   <= hds_ff;
         out_last_ff <= !sts.more;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_status      = out_st_ff;
   assign rsp_slot_out    = out_sl_ff;
   assign rsp_payload_out = out_pl_ff;
   assign rsp_dest_out    = out_ds_ff;
   assign rsp_last        = out_last_ff;

   // status to controller
   assign sts.kind      = kind;
   assign sts.out_busy  = out_vld_ff;
   assign sts.head_vld  = head_vld_ff;
   assign sts.walk_stop = dl_ff <= rd_dl;
   assign sts.link_vld  = rd_lk[IW];
   assign sts.prev_vld  = prev_vld_ff;

   // an empty list reports the sentinel deadline
   a_empty_sentinel: assert property (@(posedge clock) disable iff (reset)
      !head_vld_ff |-> head_dl_ff == ALL_ONES)
      else $error("empty list without sentinel deadline");

   // the list head is never a free slot (it drops to allocated while expiring)
   a_head_armed: assert property (@(posedge clock) disable iff (reset)
      head_vld_ff |-> mode_ff[head_ff] != MODE_FREE)
      else $error("list head is a free slot");

   // a tick never emits more than the result limit
   a_result_limit: assert property (@(posedge clock) disable iff (reset)
      32'(n_ff) <= 32'(MAX_RESULTS))
      else $error("too many expiries in one tick");

   // a real deadline never reaches the sentinel
   a_head_dl: assert property (@(posedge clock) disable iff (reset)
      head_vld_ff |-> head_dl_ff != ALL_ONES)
      else $error("armed deadline equals sentinel");

endmodule

@@ sv/sorted_timer_queue.sv @@
// Pool of SLOTS one-shot timers kept as a linked list in deadline order.
// Each request (allocate, free, set payload, arm, tick) gives one response
// transfer, except a tick that expires timers, which gives one transfer per
// expired timer (up to 16) with rsp_last on the final one. One request is
// handled at a time: arm walks the list, one entry per cycle through the
// deadline and link memories, and each expiry is fetched by memory reads.
module sorted_timer_queue #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_payload,
   input  logic [2:0]  req_destination,
   input  logic [31:0] req_delay,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot_out,
   output logic [31:0] rsp_payload_out,
   output logic [2:0]  rsp_dest_out,
   output logic        rsp_last
);
   import stq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   stq_dpath #(.SLOTS(SLOTS)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_slot        (req_slot),
      .req_payload     (req_payload),
      .req_destination (req_destination),
      .req_delay       (req_delay),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_dest_out    (rsp_dest_out),
      .rsp_last        (rsp_last)
   );

endmodule

@@ dv/stq_checker.sv @@
`timescale 1ns / 1ps

// watches both channels of the timer queue, predicts the response transfers
// of every accepted request and compares them in order
module stq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_payload,
   input  logic [2:0]  req_destination,
   input  logic [31:0] req_delay,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [3:0]  rsp_slot_out,
   input  logic [31:0] rsp_payload_out,
   input  logic [2:0]  rsp_dest_out,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending,
   output int          expiry_count,
   output int          full_count
);
   import stq_pkg::*;

   localparam int          NUM_SLOTS = 16;
   localparam logic [4:0]  NIL       = 5'd16;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [31:0] payload;
      logic [2:0]  dest;
      logic        last;
   } timer_rsp_type;

   timer_rsp_type  awaited_rsp[$];

   // shadow of the timer pool
   logic [31:0] tick_now;
   logic [1:0]  mode_sh[NUM_SLOTS];
   logic [31:0] due_sh[NUM_SLOTS];
   logic [31:0] pay_sh[NUM_SLOTS];
   logic [2:0]  dest_sh[NUM_SLOTS];
   logic [4:0]  next_sh[NUM_SLOTS];
   logic [4:0]  head_sh;

   function automatic timer_rsp_type mk(logic [2:0] st, logic [3:0] sl, logic [31:0] pl,
                                        logic [2:0] ds, logic lst);
      timer_rsp_type r;
      r.status  = st;
      r.slot    = sl;
      r.payload = pl;
      r.dest    = ds;
      r.last    = lst;
      return r;
   endfunction

   // sorted insert: ahead of every entry with an equal or later deadline
   task automatic insert_sorted(input logic [4:0] s);
      logic [4:0] prev;
      logic [4:0] cur;
      prev = NIL;
      cur  = head_sh;
      while (cur != NIL && due_sh[s] > due_sh[cur]) begin
         prev = cur;
         cur  = next_sh[cur];
      end
      next_sh[s] = cur;
      if (prev == NIL) head_sh = s;
      else next_sh[prev] = s;
   endtask

   // compute the responses of one accepted request
   task automatic predict_timer_op(input logic [2:0] op, input logic [3:0] s,
                                   input logic [31:0] pl, input logic [2:0] ds,
                                   input logic [31:0] dl);
      logic [32:0] sum;
      logic [4:0]  h;
      int          n;
      int          i;
      bit          found;
      found = 0;
      n = 0;
      case (op)
         OP_ALLOC: begin
            for (i = 0; i < NUM_SLOTS && !found; i++) begin
               if (mode_sh[i] == MODE_FREE) begin
                  mode_sh[i] = MODE_ALLOC;
                  awaited_rsp.push_back(mk(ST_OK, i[3:0], '0, '0, 1'b1));
                  found = 1;
               end
            end
            if (!found) begin
               awaited_rsp.push_back(mk(ST_NOFREE, '0, '0, '0, 1'b1));
               full_count++;
            end
         end
         OP_FREE: begin
            if (mode_sh[s] != MODE_ALLOC) begin
               awaited_rsp.push_back(mk(ST_BAD, '0, '0, '0, 1'b1));
            end else begin
               mode_sh[s] = MODE_FREE;
               awaited_rsp.push_back(mk(ST_OK, '0, '0, '0, 1'b1));
            end
         end
         OP_PAYLOAD: begin
            if (mode_sh[s] == MODE_FREE) begin
               awaited_rsp.push_back(mk(ST_BAD, '0, '0, '0, 1'b1));
            end else begin
               pay_sh[s]  = pl;
               dest_sh[s] = ds;
               awaited_rsp.push_back(mk(ST_OK, '0, '0, '0, 1'b1));
            end
         end
         OP_ARM: begin
            if (mode_sh[s] != MODE_ALLOC) begin
               awaited_rsp.push_back(mk(ST_BAD, '0, '0, '0, 1'b1));
            end else begin
               sum = {1'b0, tick_now} + {1'b0, dl};
               // saturate just below the empty-list sentinel
               if (sum[32] || sum[31:0] == ALL_ONES) due_sh[s] = DL_MAX;
               else due_sh[s] = sum[31:0];
               mode_sh[s] = MODE_ARMED;
               insert_sorted({1'b0, s});
               awaited_rsp.push_back(mk(ST_OK, '0, '0, '0, 1'b1));
            end
         end
         OP_TICK: begin
            tick_now = tick_now + 1;
            while (n < MAX_RESULTS && head_sh != NIL && due_sh[head_sh] <= tick_now) begin
               h = head_sh;
               mode_sh[h] = MODE_ALLOC;
               head_sh = next_sh[h];
               next_sh[h] = NIL;
               awaited_rsp.push_back(mk(ST_EXPIRED, h[3:0], pay_sh[h], dest_sh[h], 1'b0));
               n++;
               expiry_count++;
            end
            if (n == 0) awaited_rsp.push_back(mk(ST_NONE, '0, '0, '0, 1'b1));
            else awaited_rsp[$].last = 1'b1;
         end
         default: begin
            awaited_rsp.push_back(mk(ST_BAD, '0, '0, '0, 1'b1));
         end
      endcase
   endtask

   task automatic report(input string what, input timer_rsp_type exp_r,
                         input timer_rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display({"%0t mismatch (%s): expected st=%0d slot=%0d pl=%h dst=%0d last=%0d,",
                   " got st=%0d slot=%0d pl=%h dst=%0d last=%0d"},
                  $realtime, what, exp_r.status, exp_r.slot, exp_r.payload, exp_r.dest,
                  exp_r.last, got.status, got.slot, got.payload, got.dest, got.last);
   endtask

   always @(posedge clock) begin
      timer_rsp_type got;
      timer_rsp_type exp_r;
      if (reset) begin
         awaited_rsp.delete();
         tick_now = '0;
         head_sh  = NIL;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            mode_sh[i] = MODE_FREE;
            next_sh[i] = NIL;
            pay_sh[i]  = '0;
            dest_sh[i] = '0;
            due_sh[i]  = '0;
         end
      end else begin
         // request transfer
         if (req_valid && !req_stall)
            predict_timer_op(req_opcode, req_slot, req_payload, req_destination, req_delay);
         // response transfer
         if (rsp_valid && !rsp_stall) begin
            got = mk(rsp_status, rsp_slot_out, rsp_payload_out, rsp_dest_out, rsp_last);
            if (awaited_rsp.size() == 0) begin
               report("unexpected", '0, got);
            end else begin
               exp_r = awaited_rsp.pop_front();
               if (got !== exp_r) report("field", exp_r, got);
            end
         end
      end
      pending <= awaited_rsp.size();
   end

   initial begin
      fail_count   = 0;
      pending      = 0;
      expiry_count = 0;
      full_count   = 0;
   end

endmodule

@@ dv/tb_sorted_timer_queue.sv @@
`timescale 1ns / 1ps

module tb_sorted_timer_queue;
   import stq_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_opcode;
   logic [3:0]  req_slot;
   logic [31:0] req_payload;
   logic [2:0]  req_destination;
   logic [31:0] req_delay;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_slot_out;
   logic [31:0] rsp_payload_out;
   logic [2:0]  rsp_dest_out;
   logic        rsp_last;

   int          fail_count;
   int          pending;
   int          expiry_count;
   int          full_count;
   int          burst_left;
   int          ticks_sent;
   int          req_count;

   sorted_timer_queue dut (.*);

   stq_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver stall pattern, switching at random among four styles
   initial begin
      int style;
      int cnt;
      rsp_stall = 1'b0;
      style = 0;
      cnt = 0;
      forever begin
         @(posedge clock);
         if (cnt == 0) begin
            style = $urandom_range(0, 3);
            cnt = $urandom_range(50, 300);
         end
         cnt--;
         case (style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 80);
            default: rsp_stall <= (cnt % 8) < 3;
         endcase
      end
   end

   // one request transfer, then possibly a gap before the next burst
   task automatic send(input logic [2:0] op, input logic [3:0] s, input logic [31:0] pl,
                       input logic [2:0] ds, input logic [31:0] dl);
      req_opcode      <= op;
      req_slot        <= s;
      req_payload     <= pl;
      req_destination <= ds;
      req_delay       <= dl;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      req_count++;
      if (op == OP_TICK) ticks_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   endtask

   // payload always lands right before an arm so no timer expires unloaded
   task automatic load_and_arm(input logic [3:0] s, input logic [31:0] dl);
      send(OP_PAYLOAD, s, $urandom, 3'($urandom_range(0, 7)), $urandom);
      send(OP_ARM, s, $urandom, 3'($urandom_range(0, 7)), dl);
   endtask

   function automatic logic [31:0] pick_delay();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return $urandom;
      if (r < 85) return $urandom_range(0, 6);
      return $urandom_range(7, 40);
   endfunction

   initial begin
      int r;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= OP_TICK;
      req_slot        <= '0;
      req_payload     <= '0;
      req_destination <= '0;
      req_delay       <= '0;
      burst_left = 0;
      ticks_sent = 0;
      req_count  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: legal flow, illegal slot states and unknown opcodes
      send(OP_ALLOC, 4'd0, '0, 3'd0, '0);
      send(OP_ALLOC, 4'd0, '0, 3'd0, '0);
      send(OP_FREE, 4'd1, '0, 3'd0, '0);
      send(OP_FREE, 4'd1, '0, 3'd0, '0);
      send(OP_PAYLOAD, 4'd1, 32'hffff_ffff, 3'd7, '0);
      load_and_arm(4'd5, 32'd1);
      send(OP_PAYLOAD, 4'd0, 32'hffff_ffff, 3'd7, 32'hffff_ffff);
      send(OP_ARM, 4'd0, 32'hffff_ffff, 3'd7, 32'd0);
      send(OP_ARM, 4'd0, '0, 3'd0, 32'd3);
      send(OP_FREE, 4'd0, '0, 3'd0, '0);
      send(OP_PAYLOAD, 4'd0, 32'h0, 3'd0, '0);
      send(3'd5, 4'd15, 32'hffff_ffff, 3'd7, 32'hffff_ffff);
      send(3'd6, 4'd0, '0, 3'd0, '0);
      send(3'd7, 4'd0, '0, 3'd0, '0);
      send(OP_TICK, 4'd0, '0, 3'd0, '0);
      send(OP_TICK, 4'd0, '0, 3'd0, '0);
      send(OP_FREE, 4'd0, '0, 3'd0, '0);

      // fill the pool, arm every slot on one deadline, expire all at once
      for (int i = 0; i < 17; i++) send(OP_ALLOC, 4'd0, '0, 3'd0, '0);
      for (int i = 15; i >= 0; i--) load_and_arm(i[3:0], 32'd2);
      send(OP_TICK, 4'd0, '0, 3'd0, '0);
      send(OP_TICK, 4'd0, '0, 3'd0, '0);
      send(OP_TICK, 4'd0, '0, 3'd0, '0);

      // random mix of allocate / load+arm sequences, frees and ticks
      while (req_count < 250) begin
         r = $urandom_range(0, 99);
         if (r < 20) send(OP_ALLOC, 4'($urandom), $urandom, 3'($urandom), $urandom);
         else if (r < 30) send(OP_FREE, 4'($urandom), $urandom, 3'($urandom), $urandom);
         else if (r < 62) load_and_arm(4'($urandom), pick_delay());
         else if (r < 95) send(OP_TICK, 4'($urandom), $urandom, 3'($urandom), $urandom);
         else if (r < 98) send(OP_PAYLOAD, 4'($urandom), $urandom, 3'($urandom), $urandom);
         else send(3'($urandom_range(5, 7)), 4'($urandom), $urandom, 3'($urandom), $urandom);
      end

      // saturated deadlines: past 32 bits and landing on the sentinel
      for (int i = 0; i < 16; i++) send(OP_FREE, i[3:0], '0, 3'd0, '0);
      send(OP_ALLOC, 4'd0, '0, 3'd0, '0);
      send(OP_ALLOC, 4'd0, '0, 3'd0, '0);
      load_and_arm(4'd0, 32'hffff_ffff);
      load_and_arm(4'd1, 32'hffff_ffff - ticks_sent);
      send(OP_TICK, 4'd0, '0, 3'd0, '0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("%0d requests sent including %0d ticks", req_count, ticks_sent);
      $display("%0d timers expired, %0d allocations hit a full pool",
               expiry_count, full_count);
      if (fail_count == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
